// ===== design/signed_divider_three_modes_core_defines.svh =====
// ---------------------------------------------------------------------------
// Signed divider assertion macros
// Clocked concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef SIGNED_DIVIDER_THREE_MODES_CORE_DEFINES_SVH
`define SIGNED_DIVIDER_THREE_MODES_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every edge outside reset.
`define SD3_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sd3 assertion failed");
// Checked on every edge, reset included.
`define SD3_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sd3 assertion failed");
`else
`define SD3_ASSERT(label, prop)
`define SD3_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== design/sdiv3_pkg.sv =====
// ---------------------------------------------------------------------------
// sdiv3_pkg
// Types and constants shared by the three-mode signed divider.
// ---------------------------------------------------------------------------
package sdiv3_pkg;

  localparam int DATA_W = 64;
  localparam int HALF_W = 32;
  localparam int MODE_W = 2;
  localparam int CNT_W  = $clog2(DATA_W);

  // division_mode codes
  localparam logic [MODE_W-1:0] MODE_32_32     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_64_32     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_64_64     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_64_32_ALT = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] numerator;
    logic signed [DATA_W-1:0] denominator;
  } div_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quotient;
    logic signed [DATA_W-1:0] remainder;
    logic                     div_by_zero;
  } div_out_t;

endpackage

// ===== design/signed_divider_three_modes_core.sv =====
// ---------------------------------------------------------------------------
// signed_divider_three_modes_core
// Signed 32/32, 64/32 and 64/64 divider built on one restoring subtractor.
// ---------------------------------------------------------------------------
// Usage:
//   cfg_*  : writes division_mode (0 = 32/32, 1 or 3 = 64/32, 2 = 64/64).
//            Always ready; write only while no item is in flight.
//   in_*   : numerator/denominator transfer, taken only while the core is idle.
//   out_*  : quotient, remainder and div_by_zero, held in an output register.
// Sequence: input transfer, 64 restoring steps (one per quotient bit over the
//   full 64-bit magnitude), then the sign fix and the output register load.
//   A zero divisor in the active mode skips the loop and goes straight to the
//   sign fix in ST_FINISH, and the previously produced quotient and remainder
//   are returned again.
// Throughput: one item at a time; a new item is taken only once the last has
//   left ST_FINISH. The shared 66-bit subtractor resolves one quotient bit per cycle.
// Reset: mode returns to 32/32, held quotient/remainder clear to zero, no
//   result pending.
// Stall: a finished result waits in the output register; the core goes idle
//   and takes the next item, and that item's result waits for the register.
// ---------------------------------------------------------------------------
`include "signed_divider_three_modes_core_defines.svh"

module signed_divider_three_modes_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [sdiv3_pkg::MODE_W-1:0]            cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  sdiv3_pkg::div_in_t                      in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output sdiv3_pkg::div_out_t                     out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t                                state;
  logic [sdiv3_pkg::MODE_W-1:0]          mode;
  logic [sdiv3_pkg::DATA_W-1:0]          held_quotient;
  logic [sdiv3_pkg::DATA_W-1:0]          held_remainder;
  logic [sdiv3_pkg::DATA_W-1:0]          rem;
  logic [sdiv3_pkg::DATA_W-1:0]          quo;
  logic [sdiv3_pkg::DATA_W-1:0]          divisor;
  logic [sdiv3_pkg::CNT_W-1:0]           cnt;
  logic                                  q_neg;
  logic                                  r_neg;
  logic                                  use_held;
  logic                                  dbz;

  logic [sdiv3_pkg::DATA_W-1:0]          n_sel;
  logic [sdiv3_pkg::DATA_W-1:0]          d_sel;
  logic [sdiv3_pkg::DATA_W-1:0]          n_mag;
  logic [sdiv3_pkg::DATA_W-1:0]          d_mag;
  logic [sdiv3_pkg::DATA_W:0]            shifted;
  logic [sdiv3_pkg::DATA_W+1:0]          diff;
  logic [sdiv3_pkg::DATA_W-1:0]          rem_next;
  logic [sdiv3_pkg::DATA_W-1:0]          quo_next;
  logic [sdiv3_pkg::DATA_W-1:0]          q_fixed;
  logic [sdiv3_pkg::DATA_W-1:0]          r_fixed;
  logic                                  out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  // Operand selection per mode
  always_comb begin
    unique case (mode) inside
      sdiv3_pkg::MODE_32_32: begin
        n_sel = {{sdiv3_pkg::HALF_W{in_data.numerator[sdiv3_pkg::HALF_W-1]}},
                 in_data.numerator[sdiv3_pkg::HALF_W-1:0]};
        d_sel = {{sdiv3_pkg::HALF_W{in_data.denominator[sdiv3_pkg::HALF_W-1]}},
                 in_data.denominator[sdiv3_pkg::HALF_W-1:0]};
      end
      sdiv3_pkg::MODE_64_64: begin
        n_sel = in_data.numerator;
        d_sel = in_data.denominator;
      end
      sdiv3_pkg::MODE_64_32, sdiv3_pkg::MODE_64_32_ALT: begin
        n_sel = in_data.numerator;
        d_sel = {{sdiv3_pkg::HALF_W{in_data.denominator[sdiv3_pkg::HALF_W-1]}},
                 in_data.denominator[sdiv3_pkg::HALF_W-1:0]};
      end
      default: begin
        n_sel = in_data.numerator;
        d_sel = in_data.denominator;
      end
    endcase
  end

  assign n_mag = n_sel[sdiv3_pkg::DATA_W-1] ? (~n_sel + 1'b1) : n_sel;
  assign d_mag = d_sel[sdiv3_pkg::DATA_W-1] ? (~d_sel + 1'b1) : d_sel;

  // One restoring step: shift in the next dividend bit, try a subtract
  assign shifted  = {rem, quo[sdiv3_pkg::DATA_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, divisor};
  assign rem_next = diff[sdiv3_pkg::DATA_W+1] ? shifted[sdiv3_pkg::DATA_W-1:0]
                                              : diff[sdiv3_pkg::DATA_W-1:0];
  assign quo_next = {quo[sdiv3_pkg::DATA_W-2:0], ~diff[sdiv3_pkg::DATA_W+1]};

  assign q_fixed = q_neg ? (~quo + 1'b1) : quo;
  assign r_fixed = r_neg ? (~rem + 1'b1) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      mode           <= sdiv3_pkg::MODE_32_32;
      held_quotient  <= '0;
      held_remainder <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
      // ST_FINISH reloads the register itself when it drains
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rem      <= '0;
            quo      <= n_mag;
            divisor  <= d_mag;
            cnt      <= sdiv3_pkg::CNT_W'(sdiv3_pkg::DATA_W - 1);
            q_neg    <= n_sel[sdiv3_pkg::DATA_W-1] ^ d_sel[sdiv3_pkg::DATA_W-1];
            r_neg    <= n_sel[sdiv3_pkg::DATA_W-1];
            dbz      <= (in_data.denominator == '0);
            use_held <= (d_sel == '0);
            state    <= (d_sel == '0) ? ST_FINISH : ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.div_by_zero <= dbz;
            if (use_held) begin
              out_data.quotient  <= held_quotient;
              out_data.remainder <= held_remainder;
            end else begin
              out_data.quotient  <= q_fixed;
              out_data.remainder <= r_fixed;
              held_quotient      <= q_fixed;
              held_remainder     <= r_fixed;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Partial remainder never reaches the divisor while iterating
  `SD3_ASSERT(a_rem_below_divisor, (state == ST_DIV) |-> (rem < divisor))
  // Iteration counter walks down by one each step
  `SD3_ASSERT(a_cnt_step, (state == ST_DIV && cnt != '0) |=> (state == ST_DIV && cnt == $past(cnt) - 1'b1))
  // Last step always hands off to sign fix-up
  `SD3_ASSERT(a_last_step, (state == ST_DIV && cnt == '0) |=> (state == ST_FINISH))
  // A zero divisor never enters the loop
  `SD3_ASSERT(a_zero_skips_loop, (state == ST_DIV) |-> (divisor != '0 && !use_held))

endmodule

// ===== tb/sv/signed_divider_three_modes_core_tb.sv =====
// ---------------------------------------------------------------------------
// signed_divider_three_modes_core_tb
// Self-checking bench for the three-mode signed divider. Items go through the
// valid/ready ports under random sender and receiver idling. Each transfer is
// predicted by a behavioral divider with its own mode and held result, and
// every result is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module signed_divider_three_modes_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 80;   // covers the divide loop
  localparam int SEG_ITEMS     = 96;
  localparam int NUM_SEGS      = 12;
  localparam int LONG_HOLD     = 500;

  localparam logic [sdiv3_pkg::MODE_W-1:0] MODE_ORDER [4] =
    '{sdiv3_pkg::MODE_32_32, sdiv3_pkg::MODE_64_32, sdiv3_pkg::MODE_64_64,
      sdiv3_pkg::MODE_64_32_ALT};

  localparam logic [sdiv3_pkg::DATA_W-1:0] BOUNDARY_VALUES [10] = '{
    64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_8000_0000,
    64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_0000_0000,
    64'h0000_0001_0000_0000
  };

  // Directed operands: zero divisor first so the reset value of the held
  // result shows; then both minimum-over-minus-one cases, a divisor whose low
  // half is zero, the extremes and a mixed-sign pair.
  localparam logic [sdiv3_pkg::DATA_W-1:0] DIR_NUM [6] = '{
    64'd100, 64'hFFFF_FFFF_8000_0000, 64'h8000_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFF9, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF9
  };
  localparam logic [sdiv3_pkg::DATA_W-1:0] DIR_DEN [6] = '{
    64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0005_0000_0000, 64'h8000_0000_0000_0000, 64'd2
  };

  class div_scoreboard;
    logic [sdiv3_pkg::MODE_W-1:0] mode;
    logic [sdiv3_pkg::DATA_W-1:0] held_quo;
    logic [sdiv3_pkg::DATA_W-1:0] held_rem;
    sdiv3_pkg::div_out_t          results_due [$];
    int                           errors;

    function new();
      mode     = sdiv3_pkg::MODE_32_32;
      held_quo = '0;
      held_rem = '0;
      errors   = 0;
    endfunction

    function void set_mode(logic [sdiv3_pkg::MODE_W-1:0] m);
      mode = m;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function sdiv3_pkg::div_out_t divide(sdiv3_pkg::div_in_t d);
      logic [sdiv3_pkg::DATA_W-1:0] n;
      logic [sdiv3_pkg::DATA_W-1:0] dv;
      logic [sdiv3_pkg::DATA_W-1:0] un;
      logic [sdiv3_pkg::DATA_W-1:0] ud;
      logic [sdiv3_pkg::DATA_W-1:0] q;
      logic [sdiv3_pkg::DATA_W-1:0] r;
      sdiv3_pkg::div_out_t          res;
      case (mode)
        sdiv3_pkg::MODE_32_32: begin
          n  = {{sdiv3_pkg::HALF_W{d.numerator[sdiv3_pkg::HALF_W-1]}},
                d.numerator[sdiv3_pkg::HALF_W-1:0]};
          dv = {{sdiv3_pkg::HALF_W{d.denominator[sdiv3_pkg::HALF_W-1]}},
                d.denominator[sdiv3_pkg::HALF_W-1:0]};
        end
        sdiv3_pkg::MODE_64_64: begin
          n  = d.numerator;
          dv = d.denominator;
        end
        default: begin
          n  = d.numerator;
          dv = {{sdiv3_pkg::HALF_W{d.denominator[sdiv3_pkg::HALF_W-1]}},
                d.denominator[sdiv3_pkg::HALF_W-1:0]};
        end
      endcase
      // zero divisor in the active mode leaves the held result alone
      if (dv != '0) begin
        un = n[sdiv3_pkg::DATA_W-1] ? (~n + 1'b1) : n;
        ud = dv[sdiv3_pkg::DATA_W-1] ? (~dv + 1'b1) : dv;
        q  = un / ud;
        r  = un % ud;
        held_quo = (n[sdiv3_pkg::DATA_W-1] != dv[sdiv3_pkg::DATA_W-1]) ? (~q + 1'b1) : q;
        held_rem = n[sdiv3_pkg::DATA_W-1] ? (~r + 1'b1) : r;
      end
      res.quotient    = held_quo;
      res.remainder   = held_rem;
      res.div_by_zero = (d.denominator == '0);
      return res;
    endfunction

    function void note_input(sdiv3_pkg::div_in_t d);
      results_due.push_back(divide(d));
    endfunction

    function void check_result(sdiv3_pkg::div_out_t got);
      sdiv3_pkg::div_out_t want;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $time, got);
        return;
      end
      want = results_due.pop_front();
      if (got.quotient !== want.quotient) begin
        errors++;
        $display("%0t quotient mismatch: expected %h actual %h",
                 $time, want.quotient, got.quotient);
      end
      if (got.remainder !== want.remainder) begin
        errors++;
        $display("%0t remainder mismatch: expected %h actual %h",
                 $time, want.remainder, got.remainder);
      end
      if (got.div_by_zero !== want.div_by_zero) begin
        errors++;
        $display("%0t div_by_zero mismatch: expected %b actual %b",
                 $time, want.div_by_zero, got.div_by_zero);
      end
    endfunction
  endclass

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [sdiv3_pkg::MODE_W-1:0] cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  sdiv3_pkg::div_in_t           in_data   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  sdiv3_pkg::div_out_t          out_data;

  div_scoreboard sb;
  int send_idle_pct = 33;
  int recv_idle_pct = 69;
  int hold_left     = 0;
  bit stall_req     = 1'b0;
  bit stall_taken   = 1'b0;

  signed_divider_three_modes_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Receiver: checks each transfer, idles at random, honors long hold-offs.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (stall_req && !stall_taken) begin
        out_ready   <= 1'b0;
        hold_left   <= LONG_HOLD;
        stall_taken <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [sdiv3_pkg::DATA_W-1:0] rand_operand(bit divisor);
    logic [sdiv3_pkg::DATA_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(11))
      1, 2: v = v >> $urandom_range(sdiv3_pkg::DATA_W - 1);
      3:    v = -(v >> $urandom_range(sdiv3_pkg::DATA_W - 1));
      4:    v = {{sdiv3_pkg::HALF_W{v[sdiv3_pkg::HALF_W-1]}}, v[sdiv3_pkg::HALF_W-1:0]};
      5:    v = 64'(int'($urandom_range(40)) - 20);
      6:    v = BOUNDARY_VALUES[$urandom_range(9)];
      7:    if (divisor) v = {v[sdiv3_pkg::DATA_W-1:sdiv3_pkg::HALF_W],
                              {sdiv3_pkg::HALF_W{1'b0}}};
      8:    if (divisor) v = '0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic sdiv3_pkg::div_in_t rand_item();
    sdiv3_pkg::div_in_t d;
    d.numerator   = rand_operand(1'b0);
    d.denominator = rand_operand(1'b1);
    if ($urandom_range(24) == 0) begin
      // minimum over minus one, 32- or 64-bit flavor
      d.numerator   = $urandom_range(1) ? BOUNDARY_VALUES[3] : BOUNDARY_VALUES[5];
      d.denominator = '1;
    end
    return d;
  endfunction

  task automatic send(sdiv3_pkg::div_in_t d);
    int gap;
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(d);
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering, let every result drain, then give the core time to idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic [sdiv3_pkg::MODE_W-1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_mode(m);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sdiv3_pkg::div_in_t d;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: mode 0 runs on the reset value, the others are written
    for (int m = 0; m < 4; m++) begin
      if (m != 0) begin
        settle();
        write_mode(MODE_ORDER[m]);
      end
      for (int i = 0; i < 6; i++) begin
        d.numerator   = DIR_NUM[i];
        d.denominator = DIR_DEN[i];
        send(d);
      end
    end

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg / 4)
        0: begin send_idle_pct = 33; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      settle();
      write_mode(MODE_ORDER[seg % 4]);
      // long receiver stall so the core backs up into its input
      if (seg == 0) stall_req <= 1'b1;
      repeat (SEG_ITEMS) send(rand_item());
    end

    settle();
    if (sb.errors == 0) begin
      $display("signed_divider_three_modes_core regression: pass");
    end else begin
      $display("signed_divider_three_modes_core regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("signed_divider_three_modes_core regression: fail");
    $finish;
  end

endmodule
